// ===== src/rpbd_pkg.sv =====
`timescale 1ns / 1ps

package rpbd_pkg;

    localparam logic [7:0] PIX_THRESH = 8'd128;
    localparam logic [4:0] HDR_BITS   = 5'd16;
    localparam int         BYTE_BITS  = 8;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_META    = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_DONE    = 3'd3,
        PH_ERROR   = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0] pixel;
        logic       restart;
    } t_in;

    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 section;
        logic                 last;
        logic                 error;
    } t_out;

endpackage

// ===== src/redundant_pixel_bit_demodulator_core.sv =====
`timescale 1ns / 1ps
// A pixel transfer that completes a byte (or the header error) shows its
// result on o_out in the cycle after the transfer.
// Throughput: one pixel per cycle; the single output register is the only buffer,
// so input stalls only while that register holds a result that is stalled.
// Reset (i_rst_n low, synchronous): decode state to header phase, counters clear,
// payload_bits to 0, output register empty.
module redundant_pixel_bit_demodulator_core
    import rpbd_pkg::*;
#(
    parameter int REPEAT_COUNT = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam logic [5:0] L_REPEAT = 6'(REPEAT_COUNT);
    localparam logic [5:0] L_HALF   = 6'(REPEAT_COUNT / 2);

    logic [31:0] r_payload_bits;
    t_phase      r_phase,       n_phase;
    logic [5:0]  r_ones_count,  n_ones_count;
    logic [5:0]  r_pix_in_grp,  n_pix_in_grp;
    logic [15:0] r_meta_length, n_meta_length;
    logic [31:0] r_bit_counter, n_bit_counter;
    logic [7:0]  r_byte_shift,  n_byte_shift;
    logic        r_out_valid,   n_out_valid;
    t_out        r_out,         n_out;

    t_phase      w_ph;
    logic [5:0]  w_ones;
    logic [5:0]  w_pig;
    logic [15:0] w_meta;
    logic [31:0] w_cnt;
    logic [7:0]  w_shift;
    logic [5:0]  w_ones_inc;
    logic [5:0]  w_pig_inc;
    logic [31:0] w_cnt_inc;
    logic [7:0]  w_shift_nx;
    logic [31:0] w_whole;
    logic        w_bit;
    logic        w_in_xfer;
    logic        w_emit;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_in_xfer   = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_whole     = {r_payload_bits[31:3], 3'b000};

    always_comb begin
        n_phase       = r_phase;
        n_ones_count  = r_ones_count;
        n_pix_in_grp  = r_pix_in_grp;
        n_meta_length = r_meta_length;
        n_bit_counter = r_bit_counter;
        n_byte_shift  = r_byte_shift;
        n_out_valid   = r_out_valid & i_out_stall;
        n_out         = r_out;
        w_emit        = 1'b0;
        w_bit         = 1'b0;

        if (i_in.restart) begin
            w_ph    = PH_HEADER;
            w_ones  = '0;
            w_pig   = '0;
            w_meta  = '0;
            w_cnt   = '0;
            w_shift = '0;
        end else begin
            w_ph    = r_phase;
            w_ones  = r_ones_count;
            w_pig   = r_pix_in_grp;
            w_meta  = r_meta_length;
            w_cnt   = r_bit_counter;
            w_shift = r_byte_shift;
        end
        w_ones_inc = w_ones + {5'b0, (i_in.pixel > PIX_THRESH)};
        w_pig_inc  = w_pig + 6'd1;
        w_cnt_inc  = w_cnt + 32'd1;

        if (w_in_xfer) begin
            n_phase       = w_ph;
            n_ones_count  = w_ones;
            n_pix_in_grp  = w_pig;
            n_meta_length = w_meta;
            n_bit_counter = w_cnt;
            n_byte_shift  = w_shift;
            n_out_valid   = 1'b0;
            if (w_ph == PH_HEADER || w_ph == PH_META || w_ph == PH_PAYLOAD) begin
                if (w_pig_inc < L_REPEAT) begin
                    n_ones_count = w_ones_inc;
                    n_pix_in_grp = w_pig_inc;
                end else begin
                    w_bit         = (w_ones_inc > L_HALF);
                    n_ones_count  = '0;
                    n_pix_in_grp  = '0;
                    n_bit_counter = w_cnt_inc;
                    case (w_ph)
                        PH_HEADER: begin
                            n_meta_length = w_meta | (16'(w_bit) << w_cnt[3:0]);
                            if (w_cnt_inc >= {27'b0, HDR_BITS}) begin
                                n_bit_counter = '0;
                                if (n_meta_length[2:0] != 3'b000) begin
                                    n_phase = PH_ERROR;
                                    w_emit  = 1'b1;
                                    n_out   = '{data_byte: '0, section: 1'b0,
                                                last: 1'b0, error: 1'b1};
                                end else if (n_meta_length != 16'd0) begin
                                    n_phase = PH_META;
                                end else if (w_whole != 32'd0) begin
                                    n_phase = PH_PAYLOAD;
                                end else begin
                                    n_phase = PH_DONE;
                                end
                            end
                        end
                        PH_META: begin
                            n_byte_shift = {w_shift[6:0], w_bit};
                            if (w_cnt_inc[2:0] == 3'b000) begin
                                n_byte_shift = '0;
                                w_emit       = 1'b1;
                                n_out        = '{data_byte: {w_shift[6:0], w_bit},
                                                 section: 1'b0, last: 1'b0, error: 1'b0};
                                if (w_cnt_inc >= {16'b0, w_meta}) begin
                                    n_bit_counter = '0;
                                    if (w_whole == 32'd0) begin
                                        n_out.last = 1'b1;
                                        n_phase    = PH_DONE;
                                    end else begin
                                        n_phase = PH_PAYLOAD;
                                    end
                                end
                            end
                        end
                        default: begin
                            n_byte_shift = {w_shift[6:0], w_bit};
                            if (w_cnt_inc[2:0] == 3'b000) begin
                                n_byte_shift = '0;
                                w_emit       = 1'b1;
                                n_out        = '{data_byte: {w_shift[6:0], w_bit},
                                                 section: 1'b1,
                                                 last: (w_cnt_inc >= w_whole),
                                                 error: 1'b0};
                                if (w_cnt_inc >= w_whole) begin
                                    n_phase = PH_DONE;
                                end
                            end
                        end
                    endcase
                end
            end
            n_out_valid = w_emit;
        end
    end

    assign w_shift_nx = {w_shift[6:0], w_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_bits <= '0;
            r_phase        <= PH_HEADER;
            r_ones_count   <= '0;
            r_pix_in_grp   <= '0;
            r_meta_length  <= '0;
            r_bit_counter  <= '0;
            r_byte_shift   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_payload_bits <= i_cfg_data;
            end
            r_phase       <= n_phase;
            r_ones_count  <= n_ones_count;
            r_pix_in_grp  <= n_pix_in_grp;
            r_meta_length <= n_meta_length;
            r_bit_counter <= n_bit_counter;
            r_byte_shift  <= n_byte_shift;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= n_out;
        end
    end

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error) |->
            (r_out.data_byte == '0 && !r_out.section && !r_out.last))
        else $error("error result carries nonzero fields");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && n_out.last) |=> (r_phase == PH_DONE))
        else $error("last byte did not end decode");

    a_grp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ones_count <= r_pix_in_grp) && (r_pix_in_grp < L_REPEAT))
        else $error("vote counters out of range");

    a_shift_tie: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && w_emit && !n_out.error) |-> (n_out.data_byte == w_shift_nx))
        else $error("emitted byte differs from shift register");

endmodule
